// File: rtl/core/cfl_pkg.sv
// Shared types and constants of the cube frame loader and layer scanner.
// Used by every module of the block but cfl_ram; depends on nothing.
package cfl_pkg;

    localparam int BYTE_W            = 8;
    localparam int IDX_W             = 3;   // layer and row index width
    localparam int BANK_ADDR_W       = 2 * IDX_W;
    localparam int ADDR_W            = BANK_ADDR_W + 1;  // bank bit on top
    localparam int RAM_DEPTH         = 2 ** ADDR_W;
    localparam int CUBE_SIDE_DEFAULT = 8;

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'hff;
    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h00;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Write request from the loader into the frame RAM
    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic [BYTE_W-1:0]       data;
    } wr_req_t;

    // Which RAM bank is on display, and whether it ever held a full frame
    typedef struct packed {
        logic disp_bank;
        logic disp_written;
    } bank_stat_t;

endpackage

// File: rtl/core/cfl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module cfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cfl_loader.sv
// Serial frame loader: escape decoding, load position and bank flipping.
// Depends on cfl_pkg; drives the write port of the frame RAM.
module cfl_loader #(
    parameter int CUBE_SIDE = cfl_pkg::CUBE_SIDE_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_valid,
    input  logic [cfl_pkg::BYTE_W-1:0]  rx_byte,
    output cfl_pkg::wr_req_t            wr_req,
    output cfl_pkg::bank_stat_t         bank_stat
);

    localparam logic [cfl_pkg::IDX_W-1:0] LastIdx = cfl_pkg::IDX_W'(CUBE_SIDE - 1);

    logic                       esc_pending_reg, esc_pending_next;
    logic [cfl_pkg::IDX_W-1:0]  layer_reg, layer_next;
    logic [cfl_pkg::IDX_W-1:0]  row_reg, row_next;
    logic                       disp_bank_reg, disp_bank_next;
    logic                       disp_written_reg, disp_written_next;
    logic                       store;
    logic                       sync;

    // Escape decode
    always_comb begin
        store            = 1'b0;
        sync             = 1'b0;
        esc_pending_next = esc_pending_reg;
        if (byte_valid) begin
            esc_pending_next = !esc_pending_reg && (rx_byte == cfl_pkg::ESCAPE_BYTE);
            if (esc_pending_reg) begin
                if (rx_byte == cfl_pkg::SYNC_BYTE) begin
                    sync = 1'b1;
                end else begin
                    store = 1'b1;
                end
            end else if (rx_byte != cfl_pkg::ESCAPE_BYTE) begin
                store = 1'b1;
            end
        end
    end

    // Load position; a finished frame flips the display bank
    always_comb begin
        layer_next        = layer_reg;
        row_next          = row_reg;
        disp_bank_next    = disp_bank_reg;
        disp_written_next = disp_written_reg;
        if (sync) begin
            layer_next = '0;
            row_next   = '0;
        end else if (store) begin
            if (row_reg == LastIdx) begin
                row_next = '0;
                if (layer_reg == LastIdx) begin
                    layer_next        = '0;
                    disp_bank_next    = !disp_bank_reg;
                    disp_written_next = 1'b1;
                end else begin
                    layer_next = layer_reg + 1'b1;
                end
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pending_reg  <= 1'b0;
            layer_reg        <= '0;
            row_reg          <= '0;
            disp_bank_reg    <= 1'b0;
            disp_written_reg <= 1'b0;
        end else begin
            esc_pending_reg  <= esc_pending_next;
            layer_reg        <= layer_next;
            row_reg          <= row_next;
            disp_bank_reg    <= disp_bank_next;
            disp_written_reg <= disp_written_next;
        end
    end

    // Staging writes go to the bank not on display
    assign wr_req.en   = store;
    assign wr_req.addr = {!disp_bank_reg, layer_reg, row_reg};
    assign wr_req.data = rx_byte;

    assign bank_stat.disp_bank    = disp_bank_reg;
    assign bank_stat.disp_written = disp_written_reg;

endmodule

// File: rtl/core/cfl_scanner.sv
// Layer scanner: reads one layer of the display bank per refresh tick and
// sends select byte plus row bytes through an output register. Uses cfl_pkg.
module cfl_scanner #(
    parameter int CUBE_SIDE = cfl_pkg::CUBE_SIDE_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        tick_start,
    input  cfl_pkg::bank_stat_t         bank_stat,
    output logic                        scan_busy,
    output logic                        rd_en,
    output logic [cfl_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [cfl_pkg::BYTE_W-1:0]  rd_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cfl_pkg::BYTE_W-1:0]  m_shift_byte,
    output logic [cfl_pkg::IDX_W-1:0]   m_scan_layer,
    output logic                        m_last
);

    localparam logic [cfl_pkg::IDX_W-1:0] LastIdx = cfl_pkg::IDX_W'(CUBE_SIDE - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEL,
        ST_ROWS
    } state_t;

    state_t                     state_reg;
    logic [cfl_pkg::IDX_W-1:0]  layer_reg;
    logic [cfl_pkg::IDX_W-1:0]  row_reg;     // row held in RAM read data
    logic                       pend_reg;    // RAM read data not yet sent
    logic                       m_valid_reg;
    logic [cfl_pkg::BYTE_W-1:0] shift_byte_reg;
    logic [cfl_pkg::IDX_W-1:0]  scan_layer_reg;
    logic                       last_reg;
    logic                       load_out;
    logic [cfl_pkg::IDX_W-1:0]  rd_row;
    logic [cfl_pkg::BYTE_W-1:0] sel_byte;
    logic [cfl_pkg::BYTE_W-1:0] row_byte;

    assign load_out = !m_valid_reg || m_ready;

    // One-hot layer select
    always_comb begin
        sel_byte            = '0;
        sel_byte[layer_reg] = 1'b1;
    end

    // Display bank reads as zero until a first frame completes
    assign row_byte = bank_stat.disp_written ? rd_data : '0;

    // Read issue: next row fetched as the current one moves out
    always_comb begin
        rd_en  = 1'b0;
        rd_row = row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                rd_en = 1'b0;
            end
            ST_SEL: begin
                rd_en  = load_out;
                rd_row = '0;
            end
            ST_ROWS: begin
                if (pend_reg && load_out && (row_reg != LastIdx)) begin
                    rd_en  = 1'b1;
                    rd_row = row_reg + 1'b1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = {bank_stat.disp_bank, layer_reg, rd_row};

    // Burst sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            layer_reg   <= '0;
            row_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (tick_start) begin
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    // load_out low: a stalled request stays in place
                    if (load_out) begin
                        m_valid_reg    <= 1'b1;
                        shift_byte_reg <= sel_byte;
                        scan_layer_reg <= layer_reg;
                        last_reg       <= 1'b0;
                        row_reg        <= '0;
                        pend_reg       <= 1'b1;
                        state_reg      <= ST_ROWS;
                    end
                end
                ST_ROWS: begin
                    if (pend_reg && load_out) begin
                        m_valid_reg    <= 1'b1;
                        shift_byte_reg <= row_byte;
                        scan_layer_reg <= layer_reg;
                        last_reg       <= (row_reg == LastIdx);
                        if (row_reg == LastIdx) begin
                            pend_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                            layer_reg <= (layer_reg == LastIdx) ? '0 : layer_reg + 1'b1;
                        end else begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                default: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign scan_busy    = (state_reg != ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_shift_byte = shift_byte_reg;
    assign m_scan_layer = scan_layer_reg;
    assign m_last       = last_reg;

endmodule

// File: rtl/core/cube_frame_loader_and_layer_scanner_core.sv
// Top level of the cube frame loader and layer scanner.
// Instantiates cfl_loader, cfl_scanner and cfl_ram; uses cfl_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready): each request is either a received
//   serial byte (s_kind = 0) or a refresh tick (s_kind = 1).
//   Serial bytes are escape-decoded and written into the staging half of a
//   double-banked frame RAM; completing a frame flips the banks, so the
//   staging frame becomes the displayed one at once.
//   Result channel (m_valid/m_ready): a refresh tick yields CUBE_SIDE + 1
//   requests: the one-hot layer select byte, then the layer's row bytes,
//   m_last on the final one, all tagged with m_scan_layer.
// Timing:
//   A serial byte yields nothing on the result channel. A tick starts
//   a burst with the select byte; then, with an unstalled receiver, one
//   row byte a cycle follows from the single RAM read port. No new
//   request is taken until the burst's last byte is loaded
//   into the output register; a stalled receiver holds the burst in place.
// Reset (aresetn low, synchronous): escape state, load and refresh
//   position clear and the display reads as all zero until a first frame
//   is complete; no clearing pass is needed.
module cube_frame_loader_and_layer_scanner_core #(
    parameter int CUBE_SIDE = cfl_pkg::CUBE_SIDE_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [cfl_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cfl_pkg::BYTE_W-1:0]  m_shift_byte,
    output logic [cfl_pkg::IDX_W-1:0]   m_scan_layer,
    output logic                        m_last
);

    cfl_pkg::wr_req_t            wr_req;
    cfl_pkg::bank_stat_t         bank_stat;
    logic                        scan_busy;
    logic                        accept;
    logic                        byte_valid;
    logic                        tick_start;
    logic                        rd_en;
    logic [cfl_pkg::ADDR_W-1:0]  rd_addr;
    logic [cfl_pkg::BYTE_W-1:0]  rd_data;

    // Request steering
    assign s_ready    = !scan_busy;
    assign accept     = s_valid && s_ready;
    assign byte_valid = accept && (s_kind == cfl_pkg::KIND_BYTE);
    assign tick_start = accept && (s_kind == cfl_pkg::KIND_TICK);

    cfl_loader #(
        .CUBE_SIDE (CUBE_SIDE)
    ) u_loader (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .rx_byte    (s_rx_byte),
        .wr_req     (wr_req),
        .bank_stat  (bank_stat)
    );

    cfl_ram #(
        .WIDTH (cfl_pkg::BYTE_W),
        .DEPTH (cfl_pkg::RAM_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (wr_req.en),
        .waddr (wr_req.addr),
        .wdata (wr_req.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cfl_scanner #(
        .CUBE_SIDE (CUBE_SIDE)
    ) u_scanner (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_start   (tick_start),
        .bank_stat    (bank_stat),
        .scan_busy    (scan_busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_shift_byte (m_shift_byte),
        .m_scan_layer (m_scan_layer),
        .m_last       (m_last)
    );

endmodule

// File: rtl/core/cfl_checker.sv
// Port-level checks for the cube frame loader and layer scanner.
// Uses cfl_pkg; bound to cube_frame_loader_and_layer_scanner_core below.
module cfl_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cfl_pkg::BYTE_W-1:0]  m_shift_byte,
    input logic [cfl_pkg::IDX_W-1:0]   m_scan_layer,
    input logic                        m_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shift_byte) &&
        $stable(m_scan_layer) && $stable(m_last))
        else $error("result changed while stalled");

    // A burst runs without gaps while the receiver keeps taking it
    a_burst_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a refresh burst");

    // One layer per burst
    a_burst_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_scan_layer == $past(m_scan_layer))
        else $error("layer changed inside a burst");

    // No new request is taken in the middle of a burst
    a_no_accept_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready during a burst");

endmodule

bind cube_frame_loader_and_layer_scanner_core cfl_checker u_cfl_checker (.*);
